FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the deframer parser RTL.
// Uses the clk and rst_n names of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled during reset.
`define LPFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LPFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/lpfd_pkg.sv
// Types and constants for the length-prefixed frame deframer.
// No dependencies.
`default_nettype none

package lpfd_pkg;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 32;
  localparam int REGION_W = 2;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [REGION_W-1:0] REGION_HEADER  = 2'd0;
  localparam logic [REGION_W-1:0] REGION_PAYLOAD = 2'd1;
  localparam logic [REGION_W-1:0] REGION_TAIL    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_CODE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 8'd1;

  localparam logic [BYTE_W-1:0] START_CODE_RST  = 8'h00;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [BYTE_W-1:0]   frame_byte;
    logic [REGION_W-1:0] region;
    logic                end_of_frame;
    logic                length_error;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lpfd_parser.sv
// Deframer core: input register, config registers and the framing state machine.
// Depends on lpfd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lpfd_parser #(
  parameter int HEADER_BYTES = 8,
  parameter int TAIL_BYTES   = 2
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [lpfd_pkg::BYTE_W-1:0]      in_rx_byte,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lpfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lpfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                  res_valid,
  input  wire logic                             res_ready,
  output lpfd_pkg::result_t                     res
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_TAIL = 2'd3;

  localparam logic [lpfd_pkg::LEN_W-1:0] HDR_LAST = lpfd_pkg::LEN_W'(HEADER_BYTES);
  localparam logic [lpfd_pkg::LEN_W-1:0] TAIL_LAST = lpfd_pkg::LEN_W'(TAIL_BYTES);
  localparam logic [lpfd_pkg::LEN_W-1:0] LEN_BYTE_FIRST = 32'd1;
  localparam logic [lpfd_pkg::LEN_W-1:0] LEN_BYTE_LAST  = 32'd4;

  logic                          s1_vld_r;
  logic [lpfd_pkg::BYTE_W-1:0]   s1_byte_r;
  logic [lpfd_pkg::BYTE_W-1:0]   start_code_r;
  logic [lpfd_pkg::LEN_W-1:0]    max_len_r;
  logic [1:0]                    phase_r, phase_nxt;
  logic [lpfd_pkg::LEN_W-1:0]    pos_r, pos_nxt;
  logic [lpfd_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [lpfd_pkg::LEN_W-1:0]    pos_inc;
  logic [lpfd_pkg::LEN_W-1:0]    len_shift;
  logic                          step;
  logic                          emit;
  lpfd_pkg::result_t             res_c;

  assign step      = s1_vld_r && res_ready;
  assign in_ready  = !s1_vld_r || res_ready;
  assign cfg_ready = 1'b1;
  assign pos_inc   = pos_r + 32'd1;
  assign len_shift = (pos_r >= LEN_BYTE_FIRST && pos_r <= LEN_BYTE_LAST) ?
                     {len_r[lpfd_pkg::LEN_W-lpfd_pkg::BYTE_W-1:0], s1_byte_r} : len_r;

  always_comb begin
    phase_nxt          = phase_r;
    pos_nxt            = pos_r;
    len_nxt            = len_r;
    emit               = 1'b1;
    res_c.frame_byte   = s1_byte_r;
    res_c.region       = lpfd_pkg::REGION_HEADER;
    res_c.end_of_frame = 1'b0;
    res_c.length_error = 1'b0;
    case (phase_r)
      PH_HEAD: begin
        len_nxt = len_shift;
        pos_nxt = pos_inc;
        if (pos_inc >= HDR_LAST) begin
          pos_nxt = '0;
          if (len_shift > max_len_r) begin
            res_c.end_of_frame = 1'b1;
            res_c.length_error = 1'b1;
            phase_nxt          = PH_HUNT;
          end else if (len_shift == '0) begin
            phase_nxt = PH_TAIL;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        res_c.region = lpfd_pkg::REGION_PAYLOAD;
        pos_nxt      = pos_inc;
        if (pos_inc >= len_r) begin
          pos_nxt   = '0;
          phase_nxt = PH_TAIL;
        end
      end
      PH_TAIL: begin
        res_c.region = lpfd_pkg::REGION_TAIL;
        pos_nxt      = pos_inc;
        if (pos_inc >= TAIL_LAST) begin
          res_c.end_of_frame = 1'b1;
          pos_nxt            = '0;
          phase_nxt          = PH_HUNT;
        end
      end
      default: begin
        if (s1_byte_r == start_code_r) begin
          phase_nxt = PH_HEAD;
          pos_nxt   = 32'd1;
          len_nxt   = '0;
        end else begin
          emit = 1'b0;
        end
      end
    endcase
  end

  assign res_valid = step && emit;
  assign res       = res_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      phase_r      <= PH_HUNT;
      pos_r        <= '0;
      len_r        <= '0;
      start_code_r <= lpfd_pkg::START_CODE_RST;
      max_len_r    <= lpfd_pkg::MAX_PAYLOAD_RST;
    end else begin
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (step) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        len_r   <= len_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lpfd_pkg::CFG_START_CODE) begin
          start_code_r <= cfg_data[lpfd_pkg::BYTE_W-1:0];
        end else if (cfg_index == lpfd_pkg::CFG_MAX_PAYLOAD) begin
          max_len_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  `LPFD_ASSERT(a_err_on_header_eof,
    res_valid && res.length_error |->
      res.end_of_frame && res.region == lpfd_pkg::REGION_HEADER,
    "length error outside last header byte")
  `LPFD_ASSERT(a_head_pos,
    phase_r == PH_HEAD |-> pos_r >= 32'd1 && pos_r < HDR_LAST,
    "header position out of range")
  `LPFD_ASSERT(a_data_pos,
    phase_r == PH_DATA |-> pos_r < len_r && len_r != '0,
    "payload position past length")
  `LPFD_ASSERT(a_tail_pos,
    phase_r == PH_TAIL |-> pos_r < TAIL_LAST,
    "tail position out of range")
  `LPFD_ASSERT(a_no_step_no_result,
    !step |-> !res_valid,
    "result without a processed item")

endmodule

`default_nettype wire

FILE: hw/rtl/lpfd_out_reg.sv
// Result register stage of the deframer output channel.
// Depends on lpfd_pkg.
`default_nettype none

module lpfd_out_reg (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  res_valid,
  output logic                       res_ready,
  input  wire lpfd_pkg::result_t     res,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output lpfd_pkg::result_t          out_res
);

  logic              vld_r;
  lpfd_pkg::result_t data_r;

  assign res_ready = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_res   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res_ready) begin
      vld_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data_r <= res;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/length_prefixed_frame_deframer_unit.sv
// Top level of the start-code, length-prefixed frame deframer.
// Depends on lpfd_pkg, lpfd_parser and lpfd_out_reg.
//
// Usage:
//   in_*  : one received byte per item (valid/ready).
//   out_* : one framed byte per result item with its region, end-of-frame
//           and length-error flags (valid/ready).
//   cfg_* : register writes, always ready; index 0 start code,
//           index 1 max payload length; other indexes are ignored.
// Path: a byte accepted into the input register is processed as its result
// is captured in the result register, which drives out_*.
// Throughput: one byte per cycle while out_* does not stall; each byte takes one
// pass through the framing state machine between the input and result registers.
// Bytes dropped while hunting produce no result.
// Reset: synchronous, clears both pipeline valids, returns to hunting and
// restores register defaults; no clearing pass.
// Stall: when out_ready is low, the result register holds, one more byte
// may wait in the input register, then in_ready drops.
`default_nettype none

module length_prefixed_frame_deframer_unit #(
  parameter int HEADER_BYTES = 8,
  parameter int TAIL_BYTES   = 2
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [lpfd_pkg::BYTE_W-1:0]       in_rx_byte,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [lpfd_pkg::BYTE_W-1:0]            out_frame_byte,
  output logic [lpfd_pkg::REGION_W-1:0]          out_region,
  output logic                                   out_end_of_frame,
  output logic                                   out_length_error,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lpfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lpfd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic              res_valid;
  logic              res_ready;
  lpfd_pkg::result_t res;
  lpfd_pkg::result_t out_res;

  lpfd_parser #(
    .HEADER_BYTES (HEADER_BYTES),
    .TAIL_BYTES   (TAIL_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  lpfd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_frame_byte   = out_res.frame_byte;
  assign out_region       = out_res.region;
  assign out_end_of_frame = out_res.end_of_frame;
  assign out_length_error = out_res.length_error;

endmodule

`default_nettype wire
